FILE: hw/rtl/mlfq_scheduler_with_aging_unit_macros.svh
// Assertion macros for the multilevel feedback scheduler.
`ifndef MLFQ_SCHEDULER_WITH_AGING_UNIT_MACROS_SVH
`define MLFQ_SCHEDULER_WITH_AGING_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked on clk and disabled during reset.
`define MLFQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, checked on clk and disabled during reset.
`define MLFQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MLFQ_ASSERT_IMP(lbl, ante, cons, msg)
`define MLFQ_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

FILE: hw/rtl/mlfq_pkg.sv
// Shared constants for the multilevel feedback scheduler.
`timescale 1ns / 1ps
`default_nettype none
package mlfq_pkg;
  localparam int DEF_NUM_PROCS  = 64;
  localparam int DEF_MAX_LEVELS = 8;
  localparam int DEF_TICK_WIDTH = 32;

  localparam int OPCODE_W = 3;
  localparam int PIDX_W   = 6;
  localparam int LIDX_W   = 3;
  localparam int TOTAL_W  = 32;
  localparam int NLVL_W   = 4;
  localparam int THR_W    = 16;
  localparam int RUN_W    = 5;
  localparam int WAIT_W   = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [OPCODE_W-1:0] OP_MARK_RUN   = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_MARK_IDLE  = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_DISPATCH   = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_SLOT_END   = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_RELEASE    = 3'd4;
  localparam logic [OPCODE_W-1:0] OP_READ_TICKS = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_LEVELS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_AGING_THR  = 1'b1;

  localparam logic [NLVL_W-1:0] NUM_LEVELS_RST = 4'd3;
endpackage
`default_nettype wire

FILE: hw/rtl/mlfq_in_if.sv
// Command channel of the scheduler.
`timescale 1ns / 1ps
`default_nettype none
interface mlfq_in_if import mlfq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [PIDX_W-1:0]   process_index;
  logic                still_runnable;
  logic [LIDX_W-1:0]   level_index;
  modport source (output valid, opcode, process_index, still_runnable, level_index,
                  input ready);
  modport sink (input valid, opcode, process_index, still_runnable, level_index,
                output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/mlfq_out_if.sv
// Result channel of the scheduler.
`timescale 1ns / 1ps
`default_nettype none
interface mlfq_out_if import mlfq_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               has_process;
  logic [PIDX_W-1:0]  chosen_process;
  logic [LIDX_W-1:0]  chosen_level;
  logic [TOTAL_W-1:0] tick_total;
  modport source (output valid, has_process, chosen_process, chosen_level, tick_total,
                  input ready);
  modport sink (input valid, has_process, chosen_process, chosen_level, tick_total,
                output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/mlfq_scheduler_with_aging_unit.sv
// Multilevel feedback scheduler with aging: top level.
//
// in_ch carries one command per transfer (mark runnable, mark not runnable,
// dispatch, slot end, release slot, read level ticks); out_ch returns exactly
// one result per command, in order. cfg_we/cfg_index/cfg_wdata write the level
// count and the aging threshold; they must be written only while the block is
// idle, which the block itself does not enforce. Commands are worked on one at
// a time by a sequencer around a process memory with one read and one write
// port; its single read port sets the timing. Dispatch first queues every
// runnable, unqueued process, then, if no choice is held, walks the levels and
// their lists for a runnable one; slot end charges the choice, then ages the
// queued entries of levels one and above. After reset a clearing pass zeroes
// all NUM_PROCS*2**clog2(MAX_LEVELS) entries (512 by default) of the level
// tick memory; in_ch.ready stays low meanwhile. A finished result waits in
// the output register; the next command is taken meanwhile and only holds at
// completion while out_ch.ready stays low.
`timescale 1ns / 1ps
`default_nettype none
`include "mlfq_scheduler_with_aging_unit_macros.svh"
module mlfq_scheduler_with_aging_unit import mlfq_pkg::*; #(
  parameter int NUM_PROCS  = DEF_NUM_PROCS,
  parameter int MAX_LEVELS = DEF_MAX_LEVELS,
  parameter int TICK_WIDTH = DEF_TICK_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  mlfq_in_if.sink               in_ch,
  mlfq_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);
  localparam int PW       = $clog2(NUM_PROCS);
  localparam int LW       = $clog2(MAX_LEVELS);
  localparam int LCW      = $clog2(MAX_LEVELS + 1);
  localparam int LTAW     = PW + LW;
  localparam int LT_DEPTH = NUM_PROCS * (2 ** LW);

  typedef struct packed {
    logic          nil;
    logic [PW-1:0] idx;
  } link_t;

  typedef struct packed {
    logic              runnable;
    logic              queued;
    logic [LW-1:0]     level;
    logic [RUN_W-1:0]  run;
    logic [WAIT_W-1:0] wait_cnt;
    link_t             link_next;
    link_t             link_prev;
  } proc_rec_t;

  localparam link_t NIL_LINK = '{nil: 1'b1, idx: '0};
  localparam logic LNK_NEXT = 1'b0;
  localparam logic LNK_PREV = 1'b1;

  localparam logic [4:0] S_CLEAR   = 5'd0;
  localparam logic [4:0] S_IDLE    = 5'd1;
  localparam logic [4:0] S_P_LOAD  = 5'd2;
  localparam logic [4:0] S_REL1    = 5'd3;
  localparam logic [4:0] S_REL_CLR = 5'd4;
  localparam logic [4:0] S_RT      = 5'd5;
  localparam logic [4:0] S_D_RD    = 5'd6;
  localparam logic [4:0] S_D_CHK   = 5'd7;
  localparam logic [4:0] S_D_WB    = 5'd8;
  localparam logic [4:0] S_D_NEXT  = 5'd9;
  localparam logic [4:0] S_D_LVL   = 5'd10;
  localparam logic [4:0] S_D_WCHK  = 5'd11;
  localparam logic [4:0] S_D_OUT   = 5'd12;
  localparam logic [4:0] S_D_RES   = 5'd13;
  localparam logic [4:0] S_E_LD    = 5'd14;
  localparam logic [4:0] S_E_LT    = 5'd15;
  localparam logic [4:0] S_E_DEC   = 5'd16;
  localparam logic [4:0] S_E_DEM   = 5'd17;
  localparam logic [4:0] S_E_WB    = 5'd18;
  localparam logic [4:0] S_A_LVL   = 5'd19;
  localparam logic [4:0] S_A_CHK   = 5'd20;
  localparam logic [4:0] S_A_PRO   = 5'd21;
  localparam logic [4:0] S_A_WB    = 5'd22;
  localparam logic [4:0] S_A_NEXT  = 5'd23;
  localparam logic [4:0] S_RM0     = 5'd24;
  localparam logic [4:0] S_RM1     = 5'd25;
  localparam logic [4:0] S_RM2     = 5'd26;
  localparam logic [4:0] S_PU0     = 5'd27;
  localparam logic [4:0] S_NB_RD   = 5'd28;
  localparam logic [4:0] S_NB_WR   = 5'd29;
  localparam logic [4:0] S_FINISH  = 5'd30;

  // Configuration
  logic [NLVL_W-1:0] num_levels_r;
  logic [THR_W-1:0]  thr_r;
  logic [LCW-1:0]    eff_l;

  // Sequencer state
  logic [4:0]    state_r, state_nxt;
  logic [4:0]    lst_ret_r, lst_ret_nxt;
  logic [4:0]    nb_ret_r, nb_ret_nxt;
  logic [OPCODE_W-1:0] op_r, op_nxt;
  logic          still_r, still_nxt;
  logic [PW-1:0] p_r, p_nxt;
  logic [PW-1:0] i_r, i_nxt;
  logic [PW-1:0] n_r, n_nxt;
  link_t         nx_r, nx_nxt;
  logic [LCW-1:0] lvl_r, lvl_nxt;
  logic [LW-1:0] push_lvl_r, push_lvl_nxt;
  logic [LW-1:0] rc_r, rc_nxt;
  logic [LTAW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [PW-1:0] nb_addr_r, nb_addr_nxt;
  logic          nb_fld_r, nb_fld_nxt;
  link_t         nb_val_r, nb_val_nxt;
  link_t         choice_r, choice_nxt;
  link_t         head_r [MAX_LEVELS];
  link_t         head_nxt [MAX_LEVELS];
  proc_rec_t     cur_r, cur_nxt;

  // Result and output register
  logic               res_has_r, res_has_nxt;
  logic [PIDX_W-1:0]  res_proc_r, res_proc_nxt;
  logic [LIDX_W-1:0]  res_lvl_r, res_lvl_nxt;
  logic [TOTAL_W-1:0] res_tick_r, res_tick_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_has_r, out_has_nxt;
  logic [PIDX_W-1:0]  out_proc_r, out_proc_nxt;
  logic [LIDX_W-1:0]  out_lvl_r, out_lvl_nxt;
  logic [TOTAL_W-1:0] out_tick_r, out_tick_nxt;

  // Process memory
  proc_rec_t     pm_mem [NUM_PROCS];
  proc_rec_t     pm_rd_r;
  logic          pv_rd_r;
  logic [NUM_PROCS-1:0] pvalid_r;
  logic          pm_we, pm_re;
  logic [PW-1:0] pm_waddr, pm_raddr;
  proc_rec_t     pm_wdata;
  proc_rec_t     rd_rec;

  // Level tick memory
  logic [TICK_WIDTH-1:0] lt_mem [LT_DEPTH];
  logic [TICK_WIDTH-1:0] lt_rd_r;
  logic                  lt_we;
  logic [LTAW-1:0]       lt_waddr, lt_raddr;
  logic [TICK_WIDTH-1:0] lt_wdata;

  logic [LW-1:0] hd_addr;
  link_t         hd_q;
  logic          in_pok, in_lok;
  logic [PW-1:0] in_p;

  always_comb begin
    if (num_levels_r == '0) eff_l = LCW'(1);
    else if (int'(num_levels_r) > MAX_LEVELS) eff_l = LCW'(MAX_LEVELS);
    else eff_l = LCW'(num_levels_r);
  end

  assign rd_rec = pv_rd_r ? pm_rd_r : '0;
  assign in_pok = int'(in_ch.process_index) < NUM_PROCS;
  assign in_lok = int'(in_ch.level_index) < MAX_LEVELS;
  assign in_p   = PW'(in_ch.process_index);

  // One level head is looked at per cycle.
  always_comb begin
    case (state_r)
      S_RM0:   hd_addr = cur_r.level;
      S_PU0:   hd_addr = push_lvl_r;
      default: hd_addr = lvl_r[LW-1:0];
    endcase
  end
  assign hd_q = head_r[hd_addr];

  assign in_ch.ready           = (state_r == S_IDLE);
  assign out_ch.valid          = out_valid_r;
  assign out_ch.has_process    = out_has_r;
  assign out_ch.chosen_process = out_proc_r;
  assign out_ch.chosen_level   = out_lvl_r;
  assign out_ch.tick_total     = out_tick_r;

  always_comb begin
    proc_rec_t         rec_v;
    logic [WAIT_W-1:0] w_v;
    state_nxt    = state_r;
    lst_ret_nxt  = lst_ret_r;
    nb_ret_nxt   = nb_ret_r;
    op_nxt       = op_r;
    still_nxt    = still_r;
    p_nxt        = p_r;
    i_nxt        = i_r;
    n_nxt        = n_r;
    nx_nxt       = nx_r;
    lvl_nxt      = lvl_r;
    push_lvl_nxt = push_lvl_r;
    rc_nxt       = rc_r;
    clr_cnt_nxt  = clr_cnt_r;
    nb_addr_nxt  = nb_addr_r;
    nb_fld_nxt   = nb_fld_r;
    nb_val_nxt   = nb_val_r;
    choice_nxt   = choice_r;
    head_nxt     = head_r;
    cur_nxt      = cur_r;
    res_has_nxt  = res_has_r;
    res_proc_nxt = res_proc_r;
    res_lvl_nxt  = res_lvl_r;
    res_tick_nxt = res_tick_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_has_nxt  = out_has_r;
    out_proc_nxt = out_proc_r;
    out_lvl_nxt  = out_lvl_r;
    out_tick_nxt = out_tick_r;
    pm_we    = 1'b0;
    pm_waddr = p_r;
    pm_wdata = cur_r;
    pm_re    = 1'b0;
    pm_raddr = p_r;
    lt_we    = 1'b0;
    lt_waddr = {p_r, cur_r.level};
    lt_wdata = '0;
    lt_raddr = {p_r, cur_r.level};
    rec_v    = rd_rec;
    w_v      = '0;

    case (state_r)
      S_CLEAR: begin
        lt_we    = 1'b1;
        lt_waddr = clr_cnt_r;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == LTAW'(LT_DEPTH - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_ch.valid) begin
          op_nxt       = in_ch.opcode;
          still_nxt    = in_ch.still_runnable;
          p_nxt        = in_p;
          res_has_nxt  = 1'b0;
          res_proc_nxt = '0;
          res_lvl_nxt  = '0;
          res_tick_nxt = '0;
          state_nxt    = S_FINISH;
          case (in_ch.opcode)
            OP_MARK_RUN, OP_MARK_IDLE, OP_RELEASE: begin
              if (in_pok) begin
                pm_re     = 1'b1;
                pm_raddr  = in_p;
                state_nxt = S_P_LOAD;
              end
            end
            OP_DISPATCH: begin
              i_nxt     = '0;
              state_nxt = S_D_RD;
            end
            OP_SLOT_END: begin
              if (!choice_r.nil) begin
                p_nxt     = choice_r.idx;
                pm_re     = 1'b1;
                pm_raddr  = choice_r.idx;
                state_nxt = S_E_LD;
              end else begin
                lvl_nxt   = LCW'(1);
                state_nxt = S_A_LVL;
              end
            end
            OP_READ_TICKS: begin
              if (in_pok && in_lok) begin
                lt_raddr  = {in_p, LW'(in_ch.level_index)};
                state_nxt = S_RT;
              end
            end
            default: state_nxt = S_FINISH;
          endcase
        end
      end
      S_P_LOAD: begin
        if (op_r == OP_RELEASE) begin
          cur_nxt     = rd_rec;
          lst_ret_nxt = S_REL1;
          state_nxt   = S_RM0;
        end else begin
          rec_v.runnable = (op_r == OP_MARK_RUN);
          pm_we     = 1'b1;
          pm_wdata  = rec_v;
          state_nxt = S_FINISH;
        end
      end
      S_REL1: begin
        rec_v          = cur_r;
        rec_v.runnable = 1'b0;
        rec_v.level    = '0;
        rec_v.run      = '0;
        rec_v.wait_cnt = '0;
        pm_we    = 1'b1;
        pm_wdata = rec_v;
        if (!choice_r.nil && choice_r.idx == p_r) choice_nxt = NIL_LINK;
        rc_nxt    = '0;
        state_nxt = S_REL_CLR;
      end
      S_REL_CLR: begin
        lt_we    = 1'b1;
        lt_waddr = {p_r, rc_r};
        rc_nxt   = rc_r + 1'b1;
        if (rc_r == '1) state_nxt = S_FINISH;
      end
      S_RT: begin
        res_tick_nxt = TOTAL_W'(lt_rd_r);
        state_nxt    = S_FINISH;
      end

      // Dispatch: enqueue sweep, then the level walk.
      S_D_RD: begin
        pm_re     = 1'b1;
        pm_raddr  = i_r;
        state_nxt = S_D_CHK;
      end
      S_D_CHK: begin
        if (rd_rec.runnable && !rd_rec.queued) begin
          cur_nxt      = rd_rec;
          p_nxt        = i_r;
          push_lvl_nxt = LW'(eff_l >> 1);
          lst_ret_nxt  = S_D_WB;
          state_nxt    = S_PU0;
        end else begin
          state_nxt = S_D_NEXT;
        end
      end
      S_D_WB: begin
        pm_we     = 1'b1;
        state_nxt = S_D_NEXT;
      end
      S_D_NEXT: begin
        if (i_r == PW'(NUM_PROCS - 1)) begin
          lvl_nxt   = '0;
          state_nxt = choice_r.nil ? S_D_LVL : S_D_OUT;
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = S_D_RD;
        end
      end
      S_D_LVL: begin
        if (lvl_r >= eff_l) begin
          state_nxt = S_D_OUT;
        end else if (hd_q.nil) begin
          lvl_nxt = lvl_r + 1'b1;
        end else begin
          n_nxt     = hd_q.idx;
          pm_re     = 1'b1;
          pm_raddr  = hd_q.idx;
          state_nxt = S_D_WCHK;
        end
      end
      S_D_WCHK: begin
        if (rd_rec.runnable) begin
          choice_nxt = '{nil: 1'b0, idx: n_r};
          state_nxt  = S_D_OUT;
        end else if (rd_rec.link_next.nil) begin
          lvl_nxt   = lvl_r + 1'b1;
          state_nxt = S_D_LVL;
        end else begin
          n_nxt    = rd_rec.link_next.idx;
          pm_re    = 1'b1;
          pm_raddr = rd_rec.link_next.idx;
        end
      end
      S_D_OUT: begin
        if (!choice_r.nil) begin
          pm_re     = 1'b1;
          pm_raddr  = choice_r.idx;
          state_nxt = S_D_RES;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_D_RES: begin
        if (rd_rec.runnable) begin
          res_has_nxt  = 1'b1;
          res_proc_nxt = PIDX_W'(choice_r.idx);
          res_lvl_nxt  = LIDX_W'(rd_rec.level);
        end
        state_nxt = S_FINISH;
      end

      // Slot end: charge the choice, then age levels one and above.
      S_E_LD: begin
        cur_nxt = rd_rec;
        if (rd_rec.runnable) begin
          if (rd_rec.run != '1) cur_nxt.run = rd_rec.run + 1'b1;
          cur_nxt.runnable = still_r;
          lt_raddr  = {p_r, rd_rec.level};
          state_nxt = S_E_LT;
        end else begin
          state_nxt = S_E_DEC;
        end
      end
      S_E_LT: begin
        lt_we     = 1'b1;
        lt_wdata  = (lt_rd_r != '1) ? lt_rd_r + 1'b1 : lt_rd_r;
        state_nxt = S_E_DEC;
      end
      S_E_DEC: begin
        if (!cur_r.runnable) begin
          choice_nxt  = NIL_LINK;
          lst_ret_nxt = S_E_WB;
          state_nxt   = S_RM0;
        end else if (int'(cur_r.run) >= 2 * (int'(cur_r.level) + 1)) begin
          choice_nxt  = NIL_LINK;
          lst_ret_nxt = S_E_DEM;
          state_nxt   = S_RM0;
        end else begin
          state_nxt = S_E_WB;
        end
      end
      S_E_DEM: begin
        cur_nxt.run = '0;
        if ((LCW'(cur_r.level) + 1'b1) < eff_l) push_lvl_nxt = cur_r.level + 1'b1;
        else push_lvl_nxt = cur_r.level;
        lst_ret_nxt = S_E_WB;
        state_nxt   = S_PU0;
      end
      S_E_WB: begin
        pm_we     = 1'b1;
        lvl_nxt   = LCW'(1);
        state_nxt = S_A_LVL;
      end
      S_A_LVL: begin
        if (lvl_r >= eff_l) begin
          state_nxt = S_FINISH;
        end else if (hd_q.nil) begin
          lvl_nxt = lvl_r + 1'b1;
        end else begin
          n_nxt     = hd_q.idx;
          pm_re     = 1'b1;
          pm_raddr  = hd_q.idx;
          state_nxt = S_A_CHK;
        end
      end
      S_A_CHK: begin
        nx_nxt = rd_rec.link_next;
        if (!choice_r.nil && choice_r.idx == n_r) begin
          state_nxt = S_A_NEXT;
        end else begin
          w_v = (rd_rec.wait_cnt != '1) ? rd_rec.wait_cnt + 1'b1 : rd_rec.wait_cnt;
          cur_nxt          = rd_rec;
          cur_nxt.wait_cnt = w_v;
          p_nxt            = n_r;
          if (w_v >= thr_r) begin
            lst_ret_nxt = S_A_PRO;
            state_nxt   = S_RM0;
          end else begin
            state_nxt = S_A_WB;
          end
        end
      end
      S_A_PRO: begin
        cur_nxt.run  = '0;
        push_lvl_nxt = LW'(lvl_r - 1'b1);
        lst_ret_nxt  = S_A_WB;
        state_nxt    = S_PU0;
      end
      S_A_WB: begin
        pm_we     = 1'b1;
        state_nxt = S_A_NEXT;
      end
      S_A_NEXT: begin
        if (nx_r.nil) begin
          lvl_nxt   = lvl_r + 1'b1;
          state_nxt = S_A_LVL;
        end else begin
          n_nxt     = nx_r.idx;
          pm_re     = 1'b1;
          pm_raddr  = nx_r.idx;
          state_nxt = S_A_CHK;
        end
      end

      // Unlink the held process; nothing changes if it is not queued.
      S_RM0: begin
        if (!cur_r.queued) begin
          state_nxt = lst_ret_r;
        end else if (cur_r.link_prev.nil) begin
          head_nxt[hd_addr] = cur_r.link_next;
          state_nxt = S_RM1;
        end else begin
          nb_addr_nxt = cur_r.link_prev.idx;
          nb_fld_nxt  = LNK_NEXT;
          nb_val_nxt  = cur_r.link_next;
          nb_ret_nxt  = S_RM1;
          state_nxt   = S_NB_RD;
        end
      end
      S_RM1: begin
        if (!cur_r.link_next.nil) begin
          nb_addr_nxt = cur_r.link_next.idx;
          nb_fld_nxt  = LNK_PREV;
          nb_val_nxt  = cur_r.link_prev;
          nb_ret_nxt  = S_RM2;
          state_nxt   = S_NB_RD;
        end else begin
          state_nxt = S_RM2;
        end
      end
      S_RM2: begin
        cur_nxt.link_next = NIL_LINK;
        cur_nxt.link_prev = NIL_LINK;
        cur_nxt.queued    = 1'b0;
        state_nxt = lst_ret_r;
      end
      // Push the held process at the head of level push_lvl_r.
      S_PU0: begin
        cur_nxt.link_prev = NIL_LINK;
        cur_nxt.link_next = hd_q;
        cur_nxt.queued    = 1'b1;
        cur_nxt.level     = push_lvl_r;
        cur_nxt.wait_cnt  = '0;
        head_nxt[hd_addr] = '{nil: 1'b0, idx: p_r};
        if (!hd_q.nil) begin
          nb_addr_nxt = hd_q.idx;
          nb_fld_nxt  = LNK_PREV;
          nb_val_nxt  = '{nil: 1'b0, idx: p_r};
          nb_ret_nxt  = lst_ret_r;
          state_nxt   = S_NB_RD;
        end else begin
          state_nxt = lst_ret_r;
        end
      end
      S_NB_RD: begin
        pm_re     = 1'b1;
        pm_raddr  = nb_addr_r;
        state_nxt = S_NB_WR;
      end
      S_NB_WR: begin
        if (nb_fld_r == LNK_NEXT) rec_v.link_next = nb_val_r;
        else rec_v.link_prev = nb_val_r;
        pm_we     = 1'b1;
        pm_waddr  = nb_addr_r;
        pm_wdata  = rec_v;
        state_nxt = nb_ret_r;
      end
      S_FINISH: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_has_nxt   = res_has_r;
          out_proc_nxt  = res_proc_r;
          out_lvl_nxt   = res_lvl_r;
          out_tick_nxt  = res_tick_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      choice_r    <= NIL_LINK;
      out_valid_r <= 1'b0;
      lst_ret_r   <= S_IDLE;
      nb_ret_r    <= S_IDLE;
      for (int k = 0; k < MAX_LEVELS; k++) head_r[k] <= NIL_LINK;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      choice_r    <= choice_nxt;
      out_valid_r <= out_valid_nxt;
      lst_ret_r   <= lst_ret_nxt;
      nb_ret_r    <= nb_ret_nxt;
      head_r      <= head_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    still_r    <= still_nxt;
    p_r        <= p_nxt;
    i_r        <= i_nxt;
    n_r        <= n_nxt;
    nx_r       <= nx_nxt;
    lvl_r      <= lvl_nxt;
    push_lvl_r <= push_lvl_nxt;
    rc_r       <= rc_nxt;
    nb_addr_r  <= nb_addr_nxt;
    nb_fld_r   <= nb_fld_nxt;
    nb_val_r   <= nb_val_nxt;
    cur_r      <= cur_nxt;
    res_has_r  <= res_has_nxt;
    res_proc_r <= res_proc_nxt;
    res_lvl_r  <= res_lvl_nxt;
    res_tick_r <= res_tick_nxt;
    out_has_r  <= out_has_nxt;
    out_proc_r <= out_proc_nxt;
    out_lvl_r  <= out_lvl_nxt;
    out_tick_r <= out_tick_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_levels_r <= NUM_LEVELS_RST;
      thr_r        <= '0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_NUM_LEVELS) num_levels_r <= cfg_wdata[NLVL_W-1:0];
      else if (cfg_index == CFG_AGING_THR) thr_r <= cfg_wdata[THR_W-1:0];
    end
  end

  // Entries never written since reset read as an all-zero record.
  always_ff @(posedge clk) begin
    if (!rst_n) pvalid_r <= '0;
    else if (pm_we) pvalid_r[pm_waddr] <= 1'b1;
  end

  always_ff @(posedge clk) begin
    if (pm_we) pm_mem[pm_waddr] <= pm_wdata;
    if (pm_re) begin
      pm_rd_r <= pm_mem[pm_raddr];
      pv_rd_r <= pvalid_r[pm_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (lt_we) lt_mem[lt_waddr] <= lt_wdata;
    lt_rd_r <= lt_mem[lt_raddr];
  end

  `MLFQ_ASSERT_IMP(a_no_rw_clash, pm_we && pm_re, pm_waddr != pm_raddr, "process memory read and write collide")
  `MLFQ_ASSERT_NXT(a_busy_after_accept, in_ch.valid && in_ch.ready, state_r != S_IDLE, "command accepted but sequencer idle")
  `MLFQ_ASSERT_IMP(a_choice_range, !choice_r.nil, int'(choice_r.idx) < NUM_PROCS, "choice outside process table")
endmodule
`default_nettype wire

FILE: dv/mlfq_scheduler_with_aging_unit_test.sv
// Self-checking testbench for the multilevel feedback scheduler with aging.
`timescale 1ns / 1ps
module mlfq_scheduler_with_aging_unit_test;
  import mlfq_pkg::*;

  localparam logic [OPCODE_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OPCODE_W-1:0] OP_SPARE_7 = 3'd7;
  localparam int NPROC = DEF_NUM_PROCS;
  localparam int NLVL  = DEF_MAX_LEVELS;
  localparam int NONE  = -1;

  typedef struct packed {
    logic               has_process;
    logic [PIDX_W-1:0]  chosen_process;
    logic [LIDX_W-1:0]  chosen_level;
    logic [TOTAL_W-1:0] tick_total;
  } sched_result_t;

  typedef struct {
    logic [OPCODE_W-1:0] op;
    logic [PIDX_W-1:0]   pidx;
    logic                still;
    logic [LIDX_W-1:0]   lidx;
    bit                  known;
    sched_result_t       want;
  } command_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  mlfq_in_if  in_ch ();
  mlfq_out_if out_ch ();

  mlfq_scheduler_with_aging_unit dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Scheduler state as the block should hold it.
  logic [NLVL_W-1:0] level_count_reg;
  logic [THR_W-1:0]  aging_limit;
  bit                runnable [NPROC];
  bit                queued [NPROC];
  int                plevel [NPROC];
  logic [RUN_W-1:0]  run_cnt [NPROC];
  logic [WAIT_W-1:0] wait_cnt [NPROC];
  logic [TOTAL_W-1:0] lvl_ticks [NPROC][NLVL];
  int                head [NLVL];
  int                nxt [NPROC];
  int                prv [NPROC];
  int                choice;

  sched_result_t pending_results[$];
  bit failed = 1'b0;
  bit calm = 1'b0;
  bit start_hold = 1'b0;

  function automatic int levels_in_use();
    if (level_count_reg == 0) return 1;
    if (level_count_reg > NLVL) return NLVL;
    return int'(level_count_reg);
  endfunction

  function automatic void unlink(int p);
    int lv;
    if (!queued[p]) return;
    lv = plevel[p] % NLVL;
    if (prv[p] != NONE) nxt[prv[p]] = nxt[p]; else head[lv] = nxt[p];
    if (nxt[p] != NONE) prv[nxt[p]] = prv[p];
    nxt[p] = NONE;
    prv[p] = NONE;
    queued[p] = 1'b0;
  endfunction

  function automatic void push_head(int lv, int p);
    lv = lv % NLVL;
    prv[p] = NONE;
    nxt[p] = head[lv];
    if (head[lv] != NONE) prv[head[lv]] = p;
    head[lv] = p;
    queued[p] = 1'b1;
    plevel[p] = lv;
    wait_cnt[p] = '0;
  endfunction

  function automatic void clear_schedule();
    for (int i = 0; i < NPROC; i++) begin
      runnable[i] = 0; queued[i] = 0; plevel[i] = 0; run_cnt[i] = '0;
      wait_cnt[i] = '0; nxt[i] = NONE; prv[i] = NONE;
      for (int l = 0; l < NLVL; l++) lvl_ticks[i][l] = '0;
    end
    for (int l = 0; l < NLVL; l++) head[l] = NONE;
    choice = NONE;
    level_count_reg = NUM_LEVELS_RST;
    aging_limit = '0;
  endfunction

  function automatic void dispatch_pick();
    int nl, n;
    nl = levels_in_use();
    for (int i = 0; i < NPROC; i++)
      if (runnable[i] && !queued[i]) push_head(nl / 2, i);
    if (choice != NONE) return;
    for (int lv = 0; lv < nl; lv++) begin
      n = head[lv];
      for (int g = 0; n != NONE && g < NPROC; g++) begin
        if (runnable[n]) begin
          choice = n;
          return;
        end
        n = nxt[n];
      end
    end
  endfunction

  function automatic void end_slot(bit still);
    int nl, p, pl, n, nx;
    nl = levels_in_use();
    if (choice != NONE) begin
      p = choice;
      if (runnable[p]) begin
        pl = plevel[p] % NLVL;
        if (run_cnt[p] != '1) run_cnt[p]++;
        if (lvl_ticks[p][pl] != '1) lvl_ticks[p][pl]++;
        runnable[p] = still;
      end
      if (!runnable[p]) begin
        unlink(p);
        choice = NONE;
      end else begin
        pl = plevel[p];
        if (run_cnt[p] >= 2 * (pl + 1)) begin
          unlink(p);
          run_cnt[p] = '0;
          push_head(pl + 1 < nl ? pl + 1 : pl, p);
          choice = NONE;
        end
      end
    end
    // Aging walk; a promoted entry lands at the head of the level above.
    for (int lv = 1; lv < nl; lv++) begin
      n = head[lv];
      for (int g = 0; n != NONE && g < NPROC; g++) begin
        nx = nxt[n];
        if (n != choice) begin
          if (wait_cnt[n] != '1) wait_cnt[n]++;
          if (wait_cnt[n] >= aging_limit) begin
            unlink(n);
            run_cnt[n] = '0;
            push_head(lv - 1, n);
          end
        end
        n = nx;
      end
    end
  endfunction

  function automatic sched_result_t apply_command(logic [OPCODE_W-1:0] op,
      logic [PIDX_W-1:0] pidx, logic still, logic [LIDX_W-1:0] lidx);
    sched_result_t r;
    int p;
    r = '0;
    p = int'(pidx);
    case (op)
      OP_MARK_RUN: runnable[p] = 1'b1;
      OP_MARK_IDLE: runnable[p] = 1'b0;
      OP_DISPATCH: begin
        dispatch_pick();
        if (choice != NONE && runnable[choice]) begin
          r.has_process = 1'b1;
          r.chosen_process = choice[PIDX_W-1:0];
          r.chosen_level = plevel[choice][LIDX_W-1:0];
        end
      end
      OP_SLOT_END: end_slot(still);
      OP_RELEASE: begin
        unlink(p);
        runnable[p] = 0; plevel[p] = 0; run_cnt[p] = '0; wait_cnt[p] = '0;
        for (int l = 0; l < NLVL; l++) lvl_ticks[p][l] = '0;
        if (choice == p) choice = NONE;
      end
      OP_READ_TICKS: r.tick_total = lvl_ticks[p][lidx];
      default: ;
    endcase
    return r;
  endfunction

  // Offers one command and waits for its transfer; valid is left high.
  task automatic send_command(logic [OPCODE_W-1:0] op, logic [PIDX_W-1:0] pidx,
      logic still, logic [LIDX_W-1:0] lidx, bit known, sched_result_t want);
    sched_result_t r;
    while (!calm && $urandom_range(0, 99) < 34) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.opcode <= op;
    in_ch.process_index <= pidx;
    in_ch.still_runnable <= still;
    in_ch.level_index <= lidx;
    do @(posedge clk); while (!in_ch.ready);
    r = apply_command(op, pidx, still, lidx);
    pending_results.push_back(known ? want : r);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_NUM_LEVELS) level_count_reg = val[NLVL_W-1:0];
    else aging_limit = val[THR_W-1:0];
  endtask

  task automatic send_random(int count);
    logic [OPCODE_W-1:0] op;
    logic [PIDX_W-1:0] pidx;
    int r;
    for (int k = 0; k < count; k++) begin
      calm = (k >= count / 3 && k < count / 3 + 60);
      r = $urandom_range(0, 99);
      pidx = ($urandom_range(0, 99) < 15) ? PIDX_W'($urandom_range(0, 63))
                                          : PIDX_W'($urandom_range(0, 11));
      if (r < 20) op = OP_MARK_RUN;
      else if (r < 27) op = OP_MARK_IDLE;
      else if (r < 52) op = OP_DISPATCH;
      else if (r < 82) op = OP_SLOT_END;
      else if (r < 87) op = OP_RELEASE;
      else if (r < 96) op = OP_READ_TICKS;
      else op = $urandom_range(0, 1) ? OP_SPARE_6 : OP_SPARE_7;
      send_command(op, pidx, $urandom_range(0, 3) != 0, LIDX_W'($urandom_range(0, 7)),
                   1'b0, '0);
    end
    calm = 1'b0;
  endtask

  command_row_t directed [25];

  task automatic fill_directed();
    logic [OPCODE_W-1:0] ops [25] = '{OP_READ_TICKS, OP_DISPATCH, OP_SLOT_END, OP_SPARE_6,
      OP_SPARE_7, OP_MARK_RUN, OP_MARK_RUN, OP_DISPATCH, OP_SLOT_END, OP_MARK_IDLE,
      OP_DISPATCH, OP_SLOT_END, OP_DISPATCH, OP_SLOT_END, OP_READ_TICKS, OP_RELEASE,
      OP_READ_TICKS, OP_MARK_RUN, OP_DISPATCH, OP_SLOT_END, OP_SLOT_END, OP_SLOT_END,
      OP_SLOT_END, OP_DISPATCH, OP_READ_TICKS};
    int pids [25] = '{63, 0, 0, 0, 0, 63, 0, 0, 0, 0, 0, 0, 0, 0, 63, 63, 63, 5, 0, 0, 0,
      0, 0, 0, 5};
    bit stills [25] = '{0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1, 1,
      1, 0, 0};
    int lids [25] = '{7, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 1, 0, 0, 0, 0, 0, 0,
      0, 1};
    for (int i = 0; i < 25; i++) begin
      directed[i].op = ops[i];
      directed[i].pidx = PIDX_W'(pids[i]);
      directed[i].still = stills[i];
      directed[i].lidx = LIDX_W'(lids[i]);
      // Fresh reset, spare opcodes, flag updates and a read after release all give zeros.
      directed[i].known = (i < 8 && i != 7) || i == 9 || i == 15 || i == 16 || i == 17;
      directed[i].want = '0;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      out_ch.ready <= start_hold ? 1'b0 : (calm || $urandom_range(0, 99) >= 34);
    end else begin
      out_ch.ready <= 1'b0;
    end
  end

  task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $realtime, name, want, got);
      failed = 1'b1;
    end
  endtask

  always @(posedge clk) begin
    sched_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with no command outstanding, actual %0h %0h %0h %0h",
                 $realtime, out_ch.has_process, out_ch.chosen_process,
                 out_ch.chosen_level, out_ch.tick_total);
        failed = 1'b1;
      end else begin
        want = pending_results.pop_front();
        compare_field("has_process", want.has_process, out_ch.has_process);
        compare_field("chosen_process", want.chosen_process, out_ch.chosen_process);
        compare_field("chosen_level", want.chosen_level, out_ch.chosen_level);
        compare_field("tick_total", want.tick_total, out_ch.tick_total);
      end
    end
  end

  initial begin
    #(12 * 40_000_000);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    logic [CFG_DATA_W-1:0] lv_set [6] = '{16'd1, 16'd8, 16'd0, 16'd15, 16'd4, 16'd2};
    logic [CFG_DATA_W-1:0] thr_set [6] = '{16'd65535, 16'd0, 16'd5, 16'd3, 16'd65535, 16'd1};
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.opcode <= '0;
    in_ch.process_index <= '0;
    in_ch.still_runnable <= 1'b0;
    in_ch.level_index <= '0;
    clear_schedule();
    fill_directed();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed[i])
      send_command(directed[i].op, directed[i].pidx, directed[i].still, directed[i].lidx,
                   directed[i].known, directed[i].want);
    send_random(200);
    for (int ph = 0; ph < 6; ph++) begin
      write_register(CFG_NUM_LEVELS, lv_set[ph]);
      write_register(CFG_AGING_THR, thr_set[ph]);
      // Long receiver hold-off once, so the command side backs up.
      if (ph == 2) fork
        begin
          start_hold = 1'b1;
          repeat (4000) @(posedge clk);
          start_hold = 1'b0;
        end
      join_none
      send_random(210);
    end
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (!failed) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/mlfq_pkg.sv
hw/rtl/mlfq_in_if.sv
hw/rtl/mlfq_out_if.sv
hw/rtl/mlfq_scheduler_with_aging_unit.sv
dv/mlfq_scheduler_with_aging_unit_test.sv
